/* hw/rtl/tmt_pkg.sv */
// Shared types, constants and codes for the text-mode terminal writer.
package tmt_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;
  localparam int DATA_W = 16;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CHAR_W-1:0] BS_CODE    = 8'h08;
  localparam logic [CHAR_W-1:0] TAB_CODE   = 8'h09;
  localparam logic [CHAR_W-1:0] LF_CODE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CODE    = 8'h0D;
  localparam logic [CHAR_W-1:0] PRINT_MAX  = 8'h7F;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    CMD_PRINT = 3'd0,
    CMD_BS    = 3'd1,
    CMD_TAB   = 3'd2,
    CMD_CR    = 3'd3,
    CMD_LF    = 3'd4,
    CMD_NOP   = 3'd5,
    CMD_CLEAR = 3'd6,
    CMD_READ  = 3'd7
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

endpackage

/* hw/rtl/tmt_front.sv */
// Front end: accepts items and classifies them into screen commands.
module tmt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tmt_pkg::OP_W-1:0]    operation,
  input  logic [tmt_pkg::CHAR_W-1:0]  char_code,
  input  logic [tmt_pkg::IDX_W-1:0]   cell_index,
  input  logic                        init_busy,
  input  logic                        q_full,
  output logic                        q_push,
  output tmt_pkg::cmd_t               q_cmd
);

  logic          f_valid;
  tmt_pkg::cmd_t f_cmd;
  tmt_pkg::cmd_t cls_cmd;
  logic          accept;

  assign in_ready = !init_busy && (!f_valid || !q_full);
  assign accept   = in_valid && in_ready;
  assign q_push   = f_valid && !q_full;
  assign q_cmd    = f_cmd;

  always_comb begin
    cls_cmd.char_code  = char_code;
    cls_cmd.cell_index = cell_index;
    case (operation)
      tmt_pkg::OP_PUT: begin
        if (char_code == tmt_pkg::BS_CODE) begin
          cls_cmd.kind = tmt_pkg::CMD_BS;
        end else if (char_code == tmt_pkg::TAB_CODE) begin
          cls_cmd.kind = tmt_pkg::CMD_TAB;
        end else if (char_code == tmt_pkg::CR_CODE) begin
          cls_cmd.kind = tmt_pkg::CMD_CR;
        end else if (char_code == tmt_pkg::LF_CODE) begin
          cls_cmd.kind = tmt_pkg::CMD_LF;
        end else if (char_code >= tmt_pkg::SPACE_CODE && char_code <= tmt_pkg::PRINT_MAX) begin
          cls_cmd.kind = tmt_pkg::CMD_PRINT;
        end else begin
          cls_cmd.kind = tmt_pkg::CMD_NOP;
        end
      end
      tmt_pkg::OP_CLEAR: cls_cmd.kind = tmt_pkg::CMD_CLEAR;
      tmt_pkg::OP_READ:  cls_cmd.kind = tmt_pkg::CMD_READ;
      default:           cls_cmd.kind = tmt_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= cls_cmd;
    end
  end

endmodule

/* hw/rtl/tmt_queue.sv */
// Short command queue between the front end and the screen engine.
module tmt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tmt_pkg::cmd_t head_cmd
);

  localparam int DEPTH = tmt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  tmt_pkg::cmd_t   entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CNTW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/tmt_back.sv */
// Screen engine: cell store, cursor, scroll and clear sweeps, result register.
module tmt_back #(
  parameter int COLUMNS   = tmt_pkg::COLUMNS_DEF,
  parameter int ROWS      = tmt_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tmt_pkg::TAB_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tmt_pkg::ATTR_W-1:0]  cfg_data,
  input  logic                        q_valid,
  input  tmt_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmt_pkg::POS_W-1:0]   cursor_position,
  output logic [tmt_pkg::DATA_W-1:0]  cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CNW   = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW    = $clog2(ROWS);
  localparam int RW1   = RW + 1;
  localparam int PHW   = $clog2(TAB_WIDTH);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_COPY  = 6'b001000,
    ST_BLANK = 6'b010000,
    ST_READ  = 6'b100000
  } state_t;

  logic [tmt_pkg::DATA_W-1:0] mem [CELLS];

  state_t                     state, state_next;
  logic [AW-1:0]              sc, sc_next;
  logic [CW-1:0]              col, col_next;
  logic [RW-1:0]              row, row_next;
  logic [PHW-1:0]             ph, ph_next;
  logic [tmt_pkg::ATTR_W-1:0] attr;
  logic                       out_valid_next;
  logic [tmt_pkg::DATA_W-1:0] out_data, out_data_next;
  logic                       rd_ok, rd_ok_next;
  logic [tmt_pkg::DATA_W-1:0] rd_data;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tmt_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;

  logic [AW-1:0]              pos_cur;
  logic [tmt_pkg::DATA_W-1:0] blank;
  logic                       slot_free;

  logic [CNW-1:0]             col_a;
  logic [RW1-1:0]             row_a;
  logic [PHW-1:0]             step_ph;
  logic                       step_we;
  logic [AW-1:0]              step_waddr;
  logic [tmt_pkg::DATA_W-1:0] step_wdata;
  logic                       step_scroll;
  logic [CW-1:0]              step_col;
  logic [RW-1:0]              step_row;

  assign pos_cur         = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign blank           = {attr, tmt_pkg::SPACE_CODE};
  assign slot_free       = !out_valid || out_ready;
  assign init_busy       = (state == ST_INIT);
  assign cursor_position = tmt_pkg::POS_W'(pos_cur);
  assign cell_data       = out_data;

  // Cursor update and cell write for one put command.
  always_comb begin
    col_a      = CNW'(col);
    row_a      = RW1'(row);
    step_ph    = ph;
    step_we    = 1'b0;
    step_waddr = pos_cur;
    step_wdata = {attr, q_cmd.char_code};
    case (q_cmd.kind)
      tmt_pkg::CMD_PRINT: begin
        step_we = 1'b1;
        col_a   = col_a + 1'b1;
        step_ph = (ph == PHW'(TAB_WIDTH - 1)) ? '0 : ph + 1'b1;
      end
      tmt_pkg::CMD_BS: begin
        if (col != '0) begin
          step_we    = 1'b1;
          step_waddr = pos_cur - 1'b1;
          step_wdata = blank;
          col_a      = col_a - 1'b1;
          step_ph    = (ph == '0) ? PHW'(TAB_WIDTH - 1) : ph - 1'b1;
        end
      end
      tmt_pkg::CMD_TAB: begin
        col_a   = col_a + CNW'(TAB_WIDTH) - CNW'(ph);
        step_ph = '0;
      end
      tmt_pkg::CMD_CR: begin
        col_a   = '0;
        step_ph = '0;
      end
      tmt_pkg::CMD_LF: begin
        col_a   = '0;
        row_a   = row_a + 1'b1;
        step_ph = '0;
      end
      default: begin
      end
    endcase
    if (col_a >= CNW'(COLUMNS)) begin
      col_a   = '0;
      step_ph = '0;
      row_a   = row_a + 1'b1;
    end
    step_scroll = (row_a >= RW1'(ROWS));
    step_row    = step_scroll ? RW'(ROWS - 1) : row_a[RW-1:0];
    step_col    = col_a[CW-1:0];
  end

  always_comb begin
    state_next     = state;
    sc_next        = sc;
    col_next       = col;
    row_next       = row;
    ph_next        = ph;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    rd_ok_next     = rd_ok;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sc;
    mem_wdata      = blank;
    mem_raddr      = AW'(q_cmd.cell_index);
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tmt_pkg::ATTR_RESET, tmt_pkg::SPACE_CODE};
        if (sc == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
          sc_next    = '0;
        end else begin
          sc_next = sc + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            tmt_pkg::CMD_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              ph_next    = '0;
              sc_next    = '0;
              state_next = ST_FILL;
            end
            tmt_pkg::CMD_READ: begin
              rd_ok_next = (32'(q_cmd.cell_index) < CELLS);
              state_next = ST_READ;
            end
            tmt_pkg::CMD_NOP: begin
              out_valid_next = 1'b1;
              out_data_next  = '0;
            end
            default: begin
              mem_we    = step_we;
              mem_waddr = step_waddr;
              mem_wdata = step_wdata;
              col_next  = step_col;
              row_next  = step_row;
              ph_next   = step_ph;
              if (step_scroll) begin
                sc_next    = '0;
                state_next = ST_COPY;
              end else begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
              end
            end
          endcase
        end
      end
      ST_FILL, ST_BLANK: begin
        mem_we = 1'b1;
        if (sc == AW'(CELLS - 1)) begin
          state_next     = ST_IDLE;
          sc_next        = '0;
          out_valid_next = 1'b1;
          out_data_next  = '0;
        end else begin
          sc_next = sc + 1'b1;
        end
      end
      ST_COPY: begin
        // The cell one row below is read now and written one row up next cycle.
        mem_raddr = sc + AW'(COLUMNS);
        if (sc != '0) begin
          mem_we    = 1'b1;
          mem_waddr = sc - 1'b1;
          mem_wdata = rd_data;
        end
        if (sc == AW'(CELLS - COLUMNS)) begin
          state_next = ST_BLANK;
        end else begin
          sc_next = sc + 1'b1;
        end
      end
      ST_READ: begin
        out_valid_next = 1'b1;
        out_data_next  = rd_ok ? rd_data : '0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sc        <= '0;
      col       <= '0;
      row       <= '0;
      ph        <= '0;
      out_valid <= 1'b0;
      attr      <= tmt_pkg::ATTR_RESET;
    end else begin
      state     <= state_next;
      sc        <= sc_next;
      col       <= col_next;
      row       <= row_next;
      ph        <= ph_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    rd_ok    <= rd_ok_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row) < ROWS)
    else $error("cursor row out of range");

  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && slot_free)
    else $error("command taken while the result register is held");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (col == '0) && (row == RW'(ROWS - 1)))
    else $error("scroll started with the cursor off the last line start");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_COPY || state == ST_BLANK) |=> !$rose(out_valid) ||
    (state == ST_IDLE))
    else $error("result shown in the middle of a sweep");

endmodule

/* hw/rtl/text_mode_terminal_writer.sv */
// Top level of the text-mode terminal writer.
// Items enter on the in_valid/in_ready channel with operation, char_code and
// cell_index; each item gives exactly one result on out_valid/out_ready with
// cursor_position and cell_data. The user must write the attribute byte through
// cfg_we and cfg_data only while the block is idle; the block does not enforce it.
// A front stage classifies each item and pushes it into a four-entry queue; the
// screen engine takes commands from the queue and owns the cell store, which
// has one write and one registered read port.
// A put that does not scroll, or an unused operation, passes the front register,
// the queue and the result register; a read also passes the registered read
// port. Such puts sustain one per cycle when the receiver keeps out_ready high;
// the engine takes no new command while a read is in progress. A clear walks
// every cell, one a cycle, and a scroll copies all but one row and then blanks
// the last row, again one cell a cycle, while the queue fills and in_ready drops.
// After reset the store is cleared to blanks, one cell a cycle, with in_ready
// held low.
// When the receiver stalls, the result register holds and the engine stops
// taking commands, so back pressure reaches the input once the queue is full.
module text_mode_terminal_writer #(
  parameter int COLUMNS   = tmt_pkg::COLUMNS_DEF,
  parameter int ROWS      = tmt_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tmt_pkg::TAB_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tmt_pkg::OP_W-1:0]    operation,
  input  logic [tmt_pkg::CHAR_W-1:0]  char_code,
  input  logic [tmt_pkg::IDX_W-1:0]   cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmt_pkg::POS_W-1:0]   cursor_position,
  output logic [tmt_pkg::DATA_W-1:0]  cell_data,
  input  logic                        cfg_we,
  input  logic [tmt_pkg::ATTR_W-1:0]  cfg_data
);

  logic          init_busy;
  logic          q_full;
  logic          q_push;
  tmt_pkg::cmd_t push_cmd;
  logic          q_pop;
  logic          q_valid;
  tmt_pkg::cmd_t head_cmd;

  tmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .char_code  (char_code),
    .cell_index (cell_index),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  tmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  tmt_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_data       (cell_data)
  );

endmodule
